[design/iwt_pkg.sv]
package iwt_pkg;

  // Field widths.
  localparam int NOW_W   = 48;
  localparam int CMD_W   = 2;
  localparam int MODE_W  = 2;
  localparam int CNT8_W  = 8;
  localparam int SECS_W  = 20;
  localparam int MIN_W   = 6;
  localparam int CFG_W   = 20;
  localparam int IDX_W   = 2;
  localparam int OUT_W   = 72;

  // Serial divider geometry.
  localparam int DIV_W   = 48;
  localparam int DIV_CW  = $clog2(DIV_W);

  localparam logic [CNT8_W-1:0] MAX_COUNTDOWN = 8'd10;

  localparam logic [DIV_W-1:0] MS_PER_S  = 48'd1000;
  localparam logic [DIV_W-1:0] S_PER_H   = 48'd3600;
  localparam logic [DIV_W-1:0] S_PER_M   = 48'd60;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_PAUSE = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RS_STANDBY = 2'd0,
    RS_RUN     = 2'd1,
    RS_PAUSE   = 2'd2,
    RS_DONE    = 2'd3
  } run_state_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_UNSET = 2'd0,
    MODE_UP    = 2'd1,
    MODE_DOWN  = 2'd2,
    MODE_EMOM  = 2'd3
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE      = 2'd0,
    REG_INTERVALS = 2'd1,
    REG_SECONDS   = 2'd2,
    REG_COUNTDOWN = 2'd3
  } reg_idx_t;

endpackage

[design/interval_workout_timer.sv]
// Interval workout timer.
// Requests arrive on the s_ stream: s_tuser carries the command (tick, start,
// pause, clear) and s_tdata the 48-bit millisecond time stamp. Start, pause and
// clear are taken while idle and produce nothing. A tick produces one
// display frame on the m_ stream, with all eleven frame fields packed in m_tdata.
// The frame math runs through one shared restoring divider that retires one
// quotient bit per cycle. Each divide loads the divider, retires 48 quotient
// bits and raises done. A tick in standby or complete needs four divides; a tick
// while running or paused needs up to eight. The block works on one request at a
// time: s_tready is high only between requests.
// The result sits in an output register; start, pause and clear requests are
// still accepted while a frame waits there, and a following tick finishes its
// arithmetic and then holds until the receiver takes the waiting frame.
// The cfg_ port writes one of the four settings registers per write; writes are
// expected only while the timer is idle. Reset (rst, synchronous) returns the
// timer to standby with zero times and zero settings, and drops m_tvalid.
module interval_workout_timer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [iwt_pkg::NOW_W-1:0]        s_tdata,  // [47:0] now_ms
  input  logic [iwt_pkg::CMD_W-1:0]        s_tuser,  // [1:0] command
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata from bit 0: run_state_out 2, mode_out 2, intervals_out 8,
  // countdown_out 8, set_hours 8, set_minutes 6, set_secs 6,
  // current_interval 8, show_hours 8, show_minutes 6, show_secs 6, zero pad 4.
  output logic [iwt_pkg::OUT_W-1:0]        m_tdata,
  input  logic                             cfg_we,
  input  logic [iwt_pkg::IDX_W-1:0]        cfg_index,
  input  logic [iwt_pkg::CFG_W-1:0]        cfg_data
);

  typedef enum logic [17:0] {
    ST_IDLE     = 18'h00001,
    ST_SET_H    = 18'h00002,
    ST_SET_M    = 18'h00004,
    ST_MUL      = 18'h00008,
    ST_END_ADD  = 18'h00010,
    ST_END_CMP  = 18'h00020,
    ST_CMPL     = 18'h00040,
    ST_USED     = 18'h00080,
    ST_IV_GO    = 18'h00100,
    ST_IV_MS    = 18'h00200,
    ST_IV_DIV   = 18'h00400,
    ST_DISP     = 18'h00800,
    ST_DISP_REM = 18'h01000,
    ST_DS_GO    = 18'h02000,
    ST_DS       = 18'h04000,
    ST_SHOW_H   = 18'h08000,
    ST_SHOW_M   = 18'h10000,
    ST_OUT      = 18'h20000
  } fsm_t;

  fsm_t state;

  // Settings.
  iwt_pkg::mode_t                  timer_mode;
  logic [iwt_pkg::CNT8_W-1:0]      interval_count;
  logic [iwt_pkg::SECS_W-1:0]      interval_seconds;
  logic [iwt_pkg::CNT8_W-1:0]      countdown_seconds;

  // Timer state.
  iwt_pkg::run_state_t             run_state;
  logic [iwt_pkg::NOW_W-1:0]       start_time;
  logic [iwt_pkg::NOW_W-1:0]       pause_time;

  // Per-frame working registers.
  logic [iwt_pkg::NOW_W-1:0]       cap_now;
  iwt_pkg::run_state_t             frame_state;
  logic [iwt_pkg::NOW_W-1:0]       t_sel;
  logic [iwt_pkg::NOW_W-1:0]       used;
  logic                            after_start;
  logic [27:0]                     prod;
  logic [37:0]                     prod_ms;
  logic [iwt_pkg::NOW_W:0]         end_time;
  logic [iwt_pkg::NOW_W-1:0]       disp_ms;
  logic [iwt_pkg::DIV_W-1:0]       hour_q;
  logic [iwt_pkg::CNT8_W-1:0]      set_h;
  logic [iwt_pkg::MIN_W-1:0]       set_m;
  logic [iwt_pkg::MIN_W-1:0]       set_s;
  logic [iwt_pkg::CNT8_W-1:0]      cur_iv;
  logic [iwt_pkg::CNT8_W-1:0]      show_h;
  logic [iwt_pkg::MIN_W-1:0]       show_m;
  logic [iwt_pkg::MIN_W-1:0]       show_s;

  // Divider launch and result.
  logic                            div_start;
  logic [iwt_pkg::DIV_W-1:0]       div_num;
  logic [iwt_pkg::DIV_W-1:0]       div_den;
  logic                            div_done;
  logic [iwt_pkg::DIV_W-1:0]       div_quo;
  logic [iwt_pkg::DIV_W-1:0]       div_rem;

  logic [iwt_pkg::CNT8_W-1:0]      eff_iv;
  logic [29:0]                     len_ms;
  logic [iwt_pkg::NOW_W-1:0]       paused_el;
  logic                            accept;
  iwt_pkg::cmd_t                   cmd;
  logic [iwt_pkg::SECS_W-1:0]      done_secs;

  iwt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cmd       = iwt_pkg::cmd_t'(s_tuser);
  assign eff_iv    = (timer_mode == iwt_pkg::MODE_UP || timer_mode == iwt_pkg::MODE_DOWN)
                     ? 8'd1 : interval_count;
  assign len_ms    = 30'(interval_seconds) * 30'd1000;
  assign paused_el = (pause_time > start_time) ? pause_time - start_time : '0;
  assign done_secs = (timer_mode == iwt_pkg::MODE_UP) ? interval_seconds : '0;

  // Settings port.
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_mode        <= iwt_pkg::MODE_UNSET;
      interval_count    <= '0;
      interval_seconds  <= '0;
      countdown_seconds <= '0;
    end else if (cfg_we) begin
      unique case (iwt_pkg::reg_idx_t'(cfg_index))
        iwt_pkg::REG_MODE:      timer_mode <= iwt_pkg::mode_t'(cfg_data[1:0]);
        iwt_pkg::REG_INTERVALS: interval_count <= cfg_data[7:0];
        iwt_pkg::REG_SECONDS:   interval_seconds <= cfg_data;
        iwt_pkg::REG_COUNTDOWN: begin
          // Lead-in values above the limit are dropped.
          if (cfg_data[7:0] <= iwt_pkg::MAX_COUNTDOWN) begin
            countdown_seconds <= cfg_data[7:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Control sequencer: commands, then the frame arithmetic step by step.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      run_state  <= iwt_pkg::RS_STANDBY;
      start_time <= '0;
      pause_time <= '0;
      m_tvalid   <= 1'b0;
      div_start  <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd)
              iwt_pkg::CMD_START: begin
                if (run_state == iwt_pkg::RS_PAUSE) begin
                  // Resume: shift the start so the paused elapsed time carries on.
                  start_time <= (s_tdata > paused_el) ? s_tdata - paused_el : '0;
                  pause_time <= '0;
                  run_state  <= iwt_pkg::RS_RUN;
                end else if (run_state != iwt_pkg::RS_RUN) begin
                  start_time <= s_tdata;
                  pause_time <= '0;
                  run_state  <= iwt_pkg::RS_RUN;
                end
              end
              iwt_pkg::CMD_PAUSE: begin
                if (run_state == iwt_pkg::RS_RUN) begin
                  pause_time <= s_tdata;
                  run_state  <= iwt_pkg::RS_PAUSE;
                end
              end
              iwt_pkg::CMD_CLEAR: begin
                run_state  <= iwt_pkg::RS_STANDBY;
                start_time <= '0;
                pause_time <= '0;
              end
              iwt_pkg::CMD_TICK: begin
                cap_now     <= s_tdata;
                frame_state <= run_state;
                div_start   <= 1'b1;
                div_num     <= iwt_pkg::DIV_W'(interval_seconds);
                div_den     <= iwt_pkg::S_PER_H;
                state       <= ST_SET_H;
              end
              default: ;
            endcase
          end
        end
        ST_SET_H: begin
          if (div_done) begin
            hour_q    <= div_quo;
            div_start <= 1'b1;
            div_num   <= div_rem;
            div_den   <= iwt_pkg::S_PER_M;
            state     <= ST_SET_M;
          end
        end
        ST_SET_M: begin
          if (div_done) begin
            if (hour_q > iwt_pkg::DIV_W'(255)) begin
              set_h <= 8'd255;
              set_m <= 6'd59;
              set_s <= 6'd59;
            end else begin
              set_h <= hour_q[7:0];
              set_m <= div_quo[5:0];
              set_s <= div_rem[5:0];
            end
            unique case (run_state)
              iwt_pkg::RS_STANDBY: begin
                cur_iv    <= 8'd1;
                div_start <= 1'b1;
                div_num   <= iwt_pkg::DIV_W'(interval_seconds);
                div_den   <= iwt_pkg::S_PER_H;
                state     <= ST_SHOW_H;
              end
              iwt_pkg::RS_PAUSE: begin
                t_sel <= pause_time;
                state <= ST_USED;
              end
              iwt_pkg::RS_RUN: begin
                prod  <= 28'(eff_iv) * 28'(interval_seconds);
                state <= ST_MUL;
              end
              default: state <= ST_CMPL;
            endcase
          end
        end
        ST_MUL: begin
          prod_ms <= 38'(prod) * 38'd1000;
          state   <= ST_END_ADD;
        end
        ST_END_ADD: begin
          end_time <= {1'b0, start_time} + 49'(prod_ms);
          state    <= ST_END_CMP;
        end
        ST_END_CMP: begin
          // The frame that notices completion still reports the running state.
          if ({1'b0, cap_now} > end_time) begin
            run_state <= iwt_pkg::RS_DONE;
            state     <= ST_CMPL;
          end else begin
            t_sel <= cap_now;
            state <= ST_USED;
          end
        end
        ST_CMPL: begin
          cur_iv    <= eff_iv;
          div_start <= 1'b1;
          div_num   <= iwt_pkg::DIV_W'(done_secs);
          div_den   <= iwt_pkg::S_PER_H;
          state     <= ST_SHOW_H;
        end
        ST_USED: begin
          after_start <= (t_sel > start_time);
          used        <= (t_sel > start_time) ? t_sel - start_time : '0;
          state       <= ST_IV_GO;
        end
        ST_IV_GO: begin
          if (interval_seconds == '0) begin
            cur_iv <= 8'd1;
            state  <= ST_DISP;
          end else begin
            div_start <= 1'b1;
            div_num   <= used;
            div_den   <= iwt_pkg::MS_PER_S;
            state     <= ST_IV_MS;
          end
        end
        ST_IV_MS: begin
          if (div_done) begin
            div_start <= 1'b1;
            div_num   <= div_quo;
            div_den   <= iwt_pkg::DIV_W'(interval_seconds);
            state     <= ST_IV_DIV;
          end
        end
        ST_IV_DIV: begin
          if (div_done) begin
            cur_iv <= (div_quo >= iwt_pkg::DIV_W'(255)) ? 8'd255 : div_quo[7:0] + 8'd1;
            state  <= ST_DISP;
          end
        end
        ST_DISP: begin
          state <= ST_DS_GO;
          if (!after_start) begin
            disp_ms <= '0;
          end else begin
            unique case (timer_mode)
              iwt_pkg::MODE_UP:   disp_ms <= used;
              iwt_pkg::MODE_DOWN: disp_ms <= (iwt_pkg::NOW_W'(len_ms) > used)
                                             ? iwt_pkg::NOW_W'(len_ms) - used : '0;
              iwt_pkg::MODE_EMOM: begin
                if (len_ms == '0) begin
                  disp_ms <= '0;
                end else begin
                  div_start <= 1'b1;
                  div_num   <= used;
                  div_den   <= iwt_pkg::DIV_W'(len_ms);
                  state     <= ST_DISP_REM;
                end
              end
              default: disp_ms <= '0;
            endcase
          end
        end
        ST_DISP_REM: begin
          if (div_done) begin
            disp_ms <= iwt_pkg::NOW_W'(len_ms) - div_rem;
            state   <= ST_DS_GO;
          end
        end
        ST_DS_GO: begin
          div_start <= 1'b1;
          div_num   <= disp_ms;
          div_den   <= iwt_pkg::MS_PER_S;
          state     <= ST_DS;
        end
        ST_DS: begin
          if (div_done) begin
            div_start <= 1'b1;
            div_num   <= div_quo;
            div_den   <= iwt_pkg::S_PER_H;
            state     <= ST_SHOW_H;
          end
        end
        ST_SHOW_H: begin
          if (div_done) begin
            hour_q    <= div_quo;
            div_start <= 1'b1;
            div_num   <= div_rem;
            div_den   <= iwt_pkg::S_PER_M;
            state     <= ST_SHOW_M;
          end
        end
        ST_SHOW_M: begin
          if (div_done) begin
            if (hour_q > iwt_pkg::DIV_W'(255)) begin
              show_h <= 8'd255;
              show_m <= 6'd59;
              show_s <= 6'd59;
            end else begin
              show_h <= hour_q[7:0];
              show_m <= div_quo[5:0];
              show_s <= div_rem[5:0];
            end
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          // Wait for the output register to be free.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {4'b0000, show_s, show_m, show_h, cur_iv, set_s, set_m, set_h,
                  countdown_seconds, eff_iv, timer_mode, frame_state};
    end
  end

  // The divider only reports back while the sequencer is waiting on it.
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state != ST_IDLE && state != ST_OUT))
    else $error("divider finished outside a wait state");

  // An accepted tick always starts the settings split.
  assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == iwt_pkg::CMD_TICK) |=> (state == ST_SET_H))
    else $error("tick did not start the frame sequence");

  // Completion is only ever entered from a running timer.
  assert property (@(posedge clk) disable iff (rst)
    (run_state == iwt_pkg::RS_DONE && $past(run_state) != iwt_pkg::RS_DONE)
    |-> ($past(run_state) == iwt_pkg::RS_RUN))
    else $error("complete entered from a state other than run");

endmodule

[design/iwt_div.sv]
// Restoring divider that retires one quotient bit per cycle.
module iwt_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [iwt_pkg::DIV_W-1:0]     num,
  input  logic [iwt_pkg::DIV_W-1:0]     den,
  output logic                          done,
  output logic [iwt_pkg::DIV_W-1:0]     quo,
  output logic [iwt_pkg::DIV_W-1:0]     rem
);

  logic [iwt_pkg::DIV_W-1:0]  acc;
  logic [iwt_pkg::DIV_W-1:0]  q;
  logic [iwt_pkg::DIV_CW-1:0] cnt;
  logic                       busy;
  logic [iwt_pkg::DIV_W:0]    shifted;
  logic [iwt_pkg::DIV_W+1:0]  diff;

  assign shifted = {acc, q[iwt_pkg::DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den};
  assign quo     = q;
  assign rem     = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == iwt_pkg::DIV_CW'(iwt_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      q   <= num;
    end else if (busy) begin
      if (!diff[iwt_pkg::DIV_W+1]) begin
        acc <= diff[iwt_pkg::DIV_W-1:0];
        q   <= {q[iwt_pkg::DIV_W-2:0], 1'b1};
      end else begin
        acc <= shifted[iwt_pkg::DIV_W-1:0];
        q   <= {q[iwt_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

// One expected display frame, fields in the order they sit in m_tdata.
typedef struct packed {
  logic [3:0] pad;
  logic [5:0] show_secs;
  logic [5:0] show_minutes;
  logic [7:0] show_hours;
  logic [7:0] cur_interval;
  logic [5:0] set_secs;
  logic [5:0] set_minutes;
  logic [7:0] set_hours;
  logic [7:0] countdown;
  logic [7:0] intervals;
  logic [1:0] mode;
  logic [1:0] state;
} frame_t;

// The frame predictor lives in the scoreboard: it keeps its own copy of the
// timer state and settings, updates it on every accepted request, and queues
// one expected frame for each tick.
class frame_scoreboard;
  iwt_pkg::mode_t      mode;
  logic [7:0]          count;
  logic [19:0]         secs;
  logic [7:0]          countdown;
  iwt_pkg::run_state_t state;
  logic [47:0]         start_ms;
  logic [47:0]         pause_ms;
  frame_t              pending[$];
  int                  mismatches;

  function new();
    mode = iwt_pkg::MODE_UNSET;
    count = '0;
    secs = '0;
    countdown = '0;
    state = iwt_pkg::RS_STANDBY;
    start_ms = '0;
    pause_ms = '0;
    mismatches = 0;
  endfunction

  function void write_reg(iwt_pkg::reg_idx_t idx, logic [19:0] val);
    case (idx)
      iwt_pkg::REG_MODE:      mode = iwt_pkg::mode_t'(val[1:0]);
      iwt_pkg::REG_INTERVALS: count = val[7:0];
      iwt_pkg::REG_SECONDS:   secs = val;
      iwt_pkg::REG_COUNTDOWN: begin
        if (val[7:0] <= iwt_pkg::MAX_COUNTDOWN) countdown = val[7:0];
      end
      default: ;
    endcase
  endfunction

  function logic [7:0] eff_count();
    return (mode == iwt_pkg::MODE_UP || mode == iwt_pkg::MODE_DOWN) ? 8'd1 : count;
  endfunction

  // Splits seconds into h:m:s, pinning at 255:59:59.
  function void hms(logic [63:0] s, output logic [7:0] h, output logic [5:0] m,
                    output logic [5:0] sc);
    logic [63:0] hq;
    hq = s / 64'd3600;
    if (hq > 64'd255) begin
      h = 8'd255; m = 6'd59; sc = 6'd59;
    end else begin
      h = hq[7:0];
      m = 6'((s % 64'd3600) / 64'd60);
      sc = 6'(s % 64'd60);
    end
  endfunction

  function logic [63:0] elapsed(logic [47:0] t);
    return (t > start_ms) ? 64'(t - start_ms) : 64'd0;
  endfunction

  function logic [63:0] interval_no(logic [47:0] t);
    if (secs == '0) return 64'd0;
    return (elapsed(t) / 64'd1000) / 64'(secs);
  endfunction

  function logic [63:0] shown_ms(logic [47:0] t);
    logic [63:0] used;
    logic [63:0] len;
    if (start_ms >= t) return 64'd0;
    used = 64'(t - start_ms);
    len = 64'(secs) * 64'd1000;
    case (mode)
      iwt_pkg::MODE_UP:   return used;
      iwt_pkg::MODE_DOWN: return (len > used) ? len - used : 64'd0;
      iwt_pkg::MODE_EMOM: return (len == 64'd0) ? 64'd0 : len - (used % len);
      default:            return 64'd0;
    endcase
  endfunction

  function void note_request(iwt_pkg::cmd_t cmd, logic [47:0] now);
    frame_t f;
    logic [63:0] iv;
    logic [63:0] disp;
    logic [63:0] finish;
    logic [63:0] el;
    case (cmd)
      iwt_pkg::CMD_START: begin
        if (state == iwt_pkg::RS_STANDBY || state == iwt_pkg::RS_DONE) begin
          start_ms = now; pause_ms = '0; state = iwt_pkg::RS_RUN;
        end else if (state == iwt_pkg::RS_PAUSE) begin
          el = elapsed(pause_ms);
          start_ms = (64'(now) > el) ? 48'(64'(now) - el) : 48'd0;
          pause_ms = '0; state = iwt_pkg::RS_RUN;
        end
      end
      iwt_pkg::CMD_PAUSE: begin
        if (state == iwt_pkg::RS_RUN) begin
          pause_ms = now; state = iwt_pkg::RS_PAUSE;
        end
      end
      iwt_pkg::CMD_CLEAR: begin
        state = iwt_pkg::RS_STANDBY; start_ms = '0; pause_ms = '0;
      end
      default: begin
        f = '0;
        f.state = state;
        f.mode = mode;
        f.intervals = eff_count();
        f.countdown = countdown;
        hms(64'(secs), f.set_hours, f.set_minutes, f.set_secs);
        iv = 64'd0;
        disp = 64'd0;
        if (state == iwt_pkg::RS_STANDBY) begin
          iv = 64'd1; disp = 64'(secs);
        end else if (state == iwt_pkg::RS_PAUSE) begin
          iv = interval_no(pause_ms) + 64'd1;
          disp = shown_ms(pause_ms) / 64'd1000;
        end else begin
          if (state == iwt_pkg::RS_RUN) begin
            // The frame that detects completion still reports run.
            finish = 64'(start_ms) + 64'(eff_count()) * 64'(secs) * 64'd1000;
            if (64'(now) > finish) state = iwt_pkg::RS_DONE;
            else begin
              iv = interval_no(now) + 64'd1;
              disp = shown_ms(now) / 64'd1000;
            end
          end
          if (state == iwt_pkg::RS_DONE) begin
            iv = 64'(eff_count());
            disp = (mode == iwt_pkg::MODE_UP) ? 64'(secs) : 64'd0;
          end
        end
        f.cur_interval = (iv > 64'd255) ? 8'd255 : iv[7:0];
        hms(disp, f.show_hours, f.show_minutes, f.show_secs);
        pending.push_back(f);
      end
    endcase
  endfunction

  function void check_frame(logic [71:0] got);
    frame_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected frame %h", got);
      return;
    end
    want = pending.pop_front();
    if (got !== 72'(want)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("frame mismatch: expected %h actual %h", 72'(want), got);
    end
  endfunction
endclass

module tb_top;
  logic                       clk;
  logic                       rst;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [iwt_pkg::NOW_W-1:0]  s_tdata;
  logic [iwt_pkg::CMD_W-1:0]  s_tuser;
  logic                       m_tvalid;
  logic                       m_tready;
  logic [iwt_pkg::OUT_W-1:0]  m_tdata;
  logic                       cfg_we;
  logic [iwt_pkg::IDX_W-1:0]  cfg_index;
  logic [iwt_pkg::CFG_W-1:0]  cfg_data;

  frame_scoreboard frames;
  int send_idle_pct;
  int recv_stall_pct;
  longint cycles;
  // Running clock of the workout, kept roughly monotonic for realistic runs.
  logic [47:0] clock_ms;

  interval_workout_timer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Hard limit on the run length, with room for ticks, idling and stalls.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 4000000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: stalls at random and checks every frame it takes.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) frames.check_frame(m_tdata);
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Sends one request, with random idle cycles in front, and holds it until
  // the handshake completes. s_tvalid stays high afterwards; an idle cycle,
  // the next request or drain() takes it down.
  task automatic send_request(iwt_pkg::cmd_t cmd, logic [47:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= now;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    frames.note_request(cmd, now);
  endtask

  // Lets every frame drain, then covers the block's worst-case busy time.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (frames.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(iwt_pkg::reg_idx_t idx, logic [19:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    frames.write_reg(idx, val);
  endtask

  task automatic setup(iwt_pkg::mode_t m, logic [7:0] n, logic [19:0] s,
                       logic [19:0] cd);
    write_reg(iwt_pkg::REG_MODE, 20'(m));
    write_reg(iwt_pkg::REG_INTERVALS, 20'(n));
    write_reg(iwt_pkg::REG_SECONDS, s);
    write_reg(iwt_pkg::REG_COUNTDOWN, cd);
    cfg_we <= 1'b0;
  endtask

  // Random time: mostly small steps forward, sometimes a jump, a step back or a wild
  // value so that every stamp bit toggles.
  function automatic logic [47:0] next_ms(logic [19:0] secs);
    int pick;
    logic [63:0] span;
    pick = int'($urandom_range(99));
    span = 64'(secs) * 64'd1000 + 64'd2000;
    if (pick < 70) clock_ms = clock_ms + 48'($urandom_range(0, 32'(span / 64'd3)));
    else if (pick < 85) clock_ms = clock_ms + span[47:0];
    else if (pick < 92) clock_ms = clock_ms - 48'($urandom_range(0, 5000));
    else clock_ms = 48'({$urandom, $urandom});
    return clock_ms;
  endfunction

  // A workout: start, then random ticks, pauses, resumes and clears.
  task automatic random_workout(int requests);
    int i;
    int pick;
    iwt_pkg::cmd_t cmd;
    send_request(iwt_pkg::CMD_START, next_ms(frames.secs));
    for (i = 0; i < requests; i++) begin
      pick = int'($urandom_range(99));
      if (pick < 65) cmd = iwt_pkg::CMD_TICK;
      else if (pick < 78) cmd = iwt_pkg::CMD_PAUSE;
      else if (pick < 92) cmd = iwt_pkg::CMD_START;
      else cmd = iwt_pkg::CMD_CLEAR;
      send_request(cmd, next_ms(frames.secs));
    end
  endtask

  task automatic random_settings();
    int pick;
    logic [19:0] s;
    pick = int'($urandom_range(9));
    if (pick == 0) s = 20'd921599;
    else if (pick == 1) s = '0;
    else if (pick < 4) s = 20'($urandom_range(0, 1048575));
    else s = 20'($urandom_range(1, 120));
    setup(iwt_pkg::mode_t'(2'($urandom_range(3))), 8'($urandom_range(0, 255)), s,
          20'($urandom_range(0, 255)));
  endtask

  initial begin
    int phase;
    int w;
    frames = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = iwt_pkg::CMD_TICK;
    cfg_we = 1'b0;
    cfg_index = iwt_pkg::REG_MODE;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    clock_ms = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Standby frame with reset settings, a pause outside run, then
    // start at time zero (no time after start) in unset mode, and clear.
    send_request(iwt_pkg::CMD_TICK, 48'd0);
    send_request(iwt_pkg::CMD_PAUSE, 48'd5);
    send_request(iwt_pkg::CMD_START, 48'd0);
    send_request(iwt_pkg::CMD_TICK, 48'd0);
    send_request(iwt_pkg::CMD_START, 48'd100);
    send_request(iwt_pkg::CMD_CLEAR, 48'd200);
    send_request(iwt_pkg::CMD_TICK, 48'hFFFF_FFFF_FFFF);
    drain();
    // Count up with length 255:59:59, the largest set time shown unsaturated.
    setup(iwt_pkg::MODE_UP, 8'd255, 20'd921599, 20'd10);
    send_request(iwt_pkg::CMD_START, 48'd1000);
    send_request(iwt_pkg::CMD_TICK, 48'd3_601_000);
    send_request(iwt_pkg::CMD_PAUSE, 48'd4_000_000);
    send_request(iwt_pkg::CMD_TICK, 48'd9_000_000);
    send_request(iwt_pkg::CMD_START, 48'd100);
    send_request(iwt_pkg::CMD_TICK, 48'hFFFF_FFFF_FFFF);
    drain();
    // Count down running out; an ignored countdown write above the limit.
    setup(iwt_pkg::MODE_DOWN, 8'd0, 20'd5, 20'd11);
    send_request(iwt_pkg::CMD_START, 48'd10_000);
    send_request(iwt_pkg::CMD_TICK, 48'd12_500);
    send_request(iwt_pkg::CMD_TICK, 48'd15_000);
    send_request(iwt_pkg::CMD_TICK, 48'd15_001);
    send_request(iwt_pkg::CMD_TICK, 48'd20_000);
    drain();
    // Every-minute intervals, a zero interval length, a long-running count.
    setup(iwt_pkg::MODE_EMOM, 8'd3, 20'd60, 20'd0);
    send_request(iwt_pkg::CMD_START, 48'd0);
    send_request(iwt_pkg::CMD_TICK, 48'd125_000);
    drain();
    setup(iwt_pkg::MODE_EMOM, 8'd255, 20'd0, 20'd3);
    send_request(iwt_pkg::CMD_START, 48'd0);
    send_request(iwt_pkg::CMD_TICK, 48'd0);
    drain();

    // Random part in four idling phases, new settings between workouts.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      for (w = 0; w < 10; w++) begin
        random_settings();
        random_workout(int'($urandom_range(12, 28)));
        drain();
      end
    end

    drain();
    if (frames.mismatches == 0 && frames.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
